### design/sfl_pkg.sv
package sfl_pkg;

	localparam int BUFFER_DEPTH_C = 1024;
	localparam int SAMPLE_WIDTH_C = 24;
	localparam int SINE_DEPTH_C   = 256;

	localparam int PHASE_W = 24;
	localparam int LFO_W   = 18;
	localparam int DEPTH_W = 17;
	localparam int BASE_W  = 9;
	localparam int STEP_W  = 16;
	localparam int GAIN_W  = 16;

	// lfo * depth, then * base; the swing is the product from bit 32 up
	localparam int SCALE_W   = LFO_W + DEPTH_W;
	localparam int SWING_LSB = 32;
	localparam int SWING_W   = SCALE_W + BASE_W - SWING_LSB;
	localparam int DELAY_W   = SWING_W + 1;
	localparam int FB_SHIFT  = 15;
	localparam int MUL_B_W   = 18;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVEFORM = 3'd0,
		REG_STEP     = 3'd1,
		REG_OFFSET   = 3'd2,
		REG_BASE     = 3'd3,
		REG_DEPTH    = 3'd4,
		REG_GAIN     = 3'd5
	} cfg_reg_t;

	localparam logic WAVE_TRIANGLE = 1'b1;

	localparam logic                     WAVE_RST   = WAVE_TRIANGLE;
	localparam logic [STEP_W-1:0]        STEP_RST   = 16'd94;
	localparam logic [PHASE_W-1:0]       OFFSET_RST = 24'd0;
	localparam logic [BASE_W-1:0]        BASE_RST   = 9'd96;
	localparam logic [DEPTH_W-1:0]       DEPTH_RST  = 17'd65536;
	localparam logic signed [GAIN_W-1:0] GAIN_RST   = 16'shC000;

	typedef struct packed {
		logic               load;
		logic               wave;
		logic [PHASE_W-1:0] phase;
	} lfo_req_t;

endpackage

### design/sfl_lfo.sv
module sfl_lfo #(
	parameter int SINE_TABLE_DEPTH = sfl_pkg::SINE_DEPTH_C
) (
	input  logic                     clk,
	input  sfl_pkg::lfo_req_t        req,
	output logic [sfl_pkg::LFO_W-1:0] value
);
	import sfl_pkg::*;

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int R_W   = PHASE_W - 2;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [LFO_W-1:0] TRI_MID  = LFO_W'(1) << (LFO_W - 1);
	localparam logic [LFO_W-1:0] SINE_MID = LFO_W'(1) << (LFO_W - 2);
	localparam logic [IDX_W-1:0] SINE_D   = IDX_W'(SINE_TABLE_DEPTH);

	typedef logic [LFO_W-2:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	// quarter-wave table: Q30 Taylor series, rounded half up to Q16, capped at 1.0
	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		logic signed [63:0] acc;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x   = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			x2  = (x * x) >> 30;
			acc = $signed(x);
			t   = ((x * x2) >> 30) / 64'd6;
			acc = acc - $signed(t);
			t   = ((t * x2) >> 30) / 64'd20;
			acc = acc + $signed(t);
			t   = ((t * x2) >> 30) / 64'd42;
			acc = acc - $signed(t);
			t   = ((t * x2) >> 30) / 64'd72;
			acc = acc + $signed(t);
			t   = ((t * x2) >> 30) / 64'd110;
			acc = acc - $signed(t);
			t   = ((t * x2) >> 30) / 64'd156;
			acc = acc + $signed(t);
			t   = ((t * x2) >> 30) / 64'd210;
			acc = acc - $signed(t);
			t   = ((t * x2) >> 30) / 64'd272;
			acc = acc + $signed(t);
			t   = ((t * x2) >> 30) / 64'd342;
			acc = acc - $signed(t);
			if (acc < 0) acc = 0;
			v = (64'(acc) + 64'd8192) >> 14;
			if (v > 64'd65536) v = 64'd65536;
			rom[i] = v[LFO_W-2:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	logic [1:0]             quad;
	logic [R_W-1:0]         frac;
	logic [R_W+IDX_W-1:0]   idx_prod;
	logic [IDX_W-1:0]       idx;
	logic [IDX_W-1:0]       rom_idx;
	logic [LFO_W-2:0]       sine_mag;
	logic [LFO_W-1:0]       sine_val;
	logic [LFO_W-1:0]       tri_x;
	logic [LFO_W-1:0]       tri_dist;
	logic [LFO_W-1:0]       tri_val;
	logic [LFO_W-1:0]       value_q;

	assign quad     = req.phase[PHASE_W-1 -: 2];
	assign frac     = req.phase[R_W-1:0];
	assign idx_prod = (R_W + IDX_W)'(frac) * (R_W + IDX_W)'(SINE_D);
	assign idx      = idx_prod[R_W +: IDX_W];
	// mirror the table in the odd quadrants
	assign rom_idx  = quad[0] ? SINE_D - idx : idx;
	assign sine_mag = SINE_ROM[rom_idx];
	assign sine_val = quad[1] ? SINE_MID - LFO_W'(sine_mag) : SINE_MID + LFO_W'(sine_mag);

	assign tri_x    = req.phase[PHASE_W-1 -: LFO_W];
	assign tri_dist = (tri_x >= TRI_MID) ? tri_x - TRI_MID : TRI_MID - tri_x;
	assign tri_val  = TRI_MID - tri_dist;

	always_ff @(posedge clk) begin
		if (req.load) value_q <= (req.wave == WAVE_TRIANGLE) ? tri_val : sine_val;
	end

	assign value = value_q;

endmodule

### design/stereo_flanger_unit.sv
// Sequence: an accepted beat runs scale, swing, address and read for the left side,
// then the right, then feedback and write per side; a new sample is taken only from idle.
// Six products (two modulation scales per side and two feedback gains) use one shared
// multiplier, with one read per delay memory; a stalled output holds the last step.
// Reset: registers take their defaults, write pointer and LFO phase clear; the delay
// memories are not swept, entries not written since reset read as zero via a fill flag.
module stereo_flanger_unit #(
	parameter int BUFFER_DEPTH     = sfl_pkg::BUFFER_DEPTH_C,
	parameter int SAMPLE_WIDTH     = sfl_pkg::SAMPLE_WIDTH_C,
	parameter int SINE_TABLE_DEPTH = sfl_pkg::SINE_DEPTH_C
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      left_tap,
	output logic signed [SAMPLE_WIDTH-1:0]      right_tap,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sfl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import sfl_pkg::*;

	localparam int PTR_W     = $clog2(BUFFER_DEPTH);
	localparam int MOD_STEPS = (DELAY_W > PTR_W) ? DELAY_W - PTR_W + 1 : 1;
	localparam int RED_W     = PTR_W + MOD_STEPS;
	localparam int MUL_A_W   = (SAMPLE_WIDTH + 2 > SCALE_W + 1) ? SAMPLE_WIDTH + 2 : SCALE_W + 1;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;

	localparam logic [RED_W-1:0] DEPTH_R  = RED_W'(BUFFER_DEPTH);
	localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W + 1)'(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCALE = 9'b000000010,
		ST_SWING = 9'b000000100,
		ST_ADDR  = 9'b000001000,
		ST_READ  = 9'b000010000,
		ST_FB_L  = 9'b000100000,
		ST_WR_L  = 9'b001000000,
		ST_FB_R  = 9'b010000000,
		ST_WR_R  = 9'b100000000
	} state_t;

	state_t                          state_q;
	logic                            side_q;
	logic                            wave_q;
	logic [STEP_W-1:0]               step_q;
	logic [PHASE_W-1:0]              offset_q;
	logic [BASE_W-1:0]               base_q;
	logic [DEPTH_W-1:0]              depth_q;
	logic signed [GAIN_W-1:0]        gain_q;
	logic [PTR_W-1:0]                wp_q;
	logic                            wrapped_q;
	logic [PHASE_W-1:0]              phase_q;
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  x_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic [PTR_W-1:0]                addr_q;
	logic                            addr_ok_q;
	logic                            ok_l_q;
	logic                            ok_r_q;
	logic signed [SAMPLE_WIDTH-1:0]  rd_l_q;
	logic signed [SAMPLE_WIDTH-1:0]  rd_r_q;
	logic signed [SAMPLE_WIDTH-1:0]  left_tap_q;
	logic signed [SAMPLE_WIDTH-1:0]  right_tap_q;

	logic signed [SAMPLE_WIDTH-1:0]  mem_l [BUFFER_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0]  mem_r [BUFFER_DEPTH];

	logic                            accept;
	logic                            finish;
	lfo_req_t                        lfo_req;
	logic [LFO_W-1:0]                lfo_val;
	logic [PHASE_W-1:0]              right_phase;
	logic signed [SAMPLE_WIDTH-1:0]  tap_l;
	logic signed [SAMPLE_WIDTH-1:0]  tap_r;
	logic signed [SAMPLE_WIDTH-1:0]  fb_tap;
	logic signed [SAMPLE_WIDTH:0]    fb_sum;
	logic signed [MUL_A_W-1:0]       mul_a;
	logic signed [MUL_B_W-1:0]       mul_b;
	logic signed [PROD_W-1:0]        mul_p;
	logic [DELAY_W-1:0]              delay;
	logic [RED_W-1:0]                red;
	logic [PTR_W:0]                  tap_sum;
	logic [PTR_W-1:0]                tap_idx;
	logic                            addr_ok;
	logic [PROD_W-FB_SHIFT-SAMPLE_WIDTH:0] fb_hi;
	logic                            fb_fits;
	logic signed [SAMPLE_WIDTH-1:0]  wr_data;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign finish    = (state_q == ST_WR_R) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// the one LFO loads the left phase with the accepted beat, the right phase while the left tap is read
	assign right_phase   = phase_q + offset_q;
	assign lfo_req.load  = accept || ((state_q == ST_READ) && !side_q);
	assign lfo_req.wave  = wave_q;
	assign lfo_req.phase = (state_q == ST_READ) ? right_phase : phase_q;

	sfl_lfo #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_lfo (
		.clk   (clk),
		.req   (lfo_req),
		.value (lfo_val)
	);

	assign tap_l  = ok_l_q ? rd_l_q : '0;
	assign tap_r  = ok_r_q ? rd_r_q : '0;
	assign fb_tap = (state_q == ST_FB_R) ? tap_r : tap_l;
	assign fb_sum = (SAMPLE_WIDTH + 1)'(fb_tap) + (SAMPLE_WIDTH + 1)'(x_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SCALE: begin
				mul_a = MUL_A_W'(lfo_val);
				mul_b = MUL_B_W'(depth_q);
			end
			ST_SWING: begin
				mul_a = MUL_A_W'(prod_q[SCALE_W-1:0]);
				mul_b = MUL_B_W'(base_q);
			end
			ST_FB_L, ST_FB_R: begin
				mul_a = MUL_A_W'(fb_sum);
				mul_b = MUL_B_W'(gain_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// tap delay, reduced below the buffer depth by shifted compare and subtract
	assign delay = DELAY_W'(base_q) + DELAY_W'(prod_q[SWING_LSB +: SWING_W]);

	always_comb begin
		red = RED_W'(delay);
		for (int s = MOD_STEPS - 1; s >= 0; s--) begin
			if (red >= (DEPTH_R << s)) red = red - (DEPTH_R << s);
		end
	end

	assign tap_sum = DEPTH_P + (PTR_W + 1)'(wp_q) - (PTR_W + 1)'(red);
	assign tap_idx = (tap_sum >= DEPTH_P) ? PTR_W'(tap_sum - DEPTH_P) : tap_sum[PTR_W-1:0];
	// entries below the pointer were written since reset, all of them once it wrapped
	assign addr_ok = wrapped_q || (tap_idx < wp_q);

	// floor shift by 15, then saturate
	assign fb_hi   = prod_q[PROD_W-1 : FB_SHIFT+SAMPLE_WIDTH-1];
	assign fb_fits = (&fb_hi) || !(|fb_hi);
	assign wr_data = fb_fits ? prod_q[FB_SHIFT +: SAMPLE_WIDTH]
	                         : (prod_q[PROD_W-1] ? SAT_MIN : SAT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			wave_q      <= WAVE_RST;
			step_q      <= STEP_RST;
			offset_q    <= OFFSET_RST;
			base_q      <= BASE_RST;
			depth_q     <= DEPTH_RST;
			gain_q      <= GAIN_RST;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WAVEFORM: wave_q   <= cfg_data[0];
					REG_STEP:     step_q   <= cfg_data[STEP_W-1:0];
					REG_OFFSET:   offset_q <= cfg_data[PHASE_W-1:0];
					REG_BASE:     base_q   <= cfg_data[BASE_W-1:0];
					REG_DEPTH:    depth_q  <= cfg_data[DEPTH_W-1:0];
					REG_GAIN:     gain_q   <= $signed(cfg_data[GAIN_W-1:0]);
					default: begin
					end
				endcase
			end

			if (finish) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						side_q  <= 1'b0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_SWING;
				ST_SWING: state_q <= ST_ADDR;
				ST_ADDR:  state_q <= ST_READ;
				ST_READ: begin
					if (side_q) begin
						state_q <= ST_FB_L;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_SCALE;
					end
				end
				ST_FB_L: state_q <= ST_WR_L;
				ST_WR_L: state_q <= ST_FB_R;
				ST_FB_R: state_q <= ST_WR_R;
				ST_WR_R: begin
					// hold until the output register is free
					if (finish) begin
						state_q <= ST_IDLE;
						phase_q <= phase_q + PHASE_W'(step_q);
						if (wp_q == LAST_PTR) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) x_q <= sample;
		if ((state_q == ST_SCALE) || (state_q == ST_SWING) ||
		    (state_q == ST_FB_L) || (state_q == ST_FB_R)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_ADDR) begin
			addr_q    <= tap_idx;
			addr_ok_q <= addr_ok;
		end
		if (state_q == ST_READ) begin
			if (side_q) ok_r_q <= addr_ok_q;
			else ok_l_q <= addr_ok_q;
		end
		if (finish) begin
			left_tap_q  <= tap_l;
			right_tap_q <= tap_r;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR_L) mem_l[wp_q] <= wr_data;
		if ((state_q == ST_READ) && !side_q) rd_l_q <= mem_l[addr_q];
	end

	always_ff @(posedge clk) begin
		if (finish) mem_r[wp_q] <= wr_data;
		if ((state_q == ST_READ) && side_q) rd_r_q <= mem_r[addr_q];
	end

	assign out_valid = out_valid_q;
	assign left_tap  = left_tap_q;
	assign right_tap = right_tap_q;

`ifndef SYNTHESIS
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WR_R))
		else $error("result raised outside the final write step");

	a_ptr_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(state_q == ST_WR_R))
		else $error("write pointer moved before the item completed");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ((state_q == ST_SCALE) && !side_q))
		else $error("accepted beat did not start the left side");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (addr_q <= LAST_PTR))
		else $error("tap address beyond buffer depth");

	a_fb_after_both: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FB_L) |-> ($past(state_q == ST_READ) && side_q))
		else $error("feedback started before both taps were read");
`endif

endmodule
